// ===== rtl/rgb_pcc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types of the RGB pulse color classifier.
package rgb_pcc_pkg;

  localparam int NUM_CHANNELS   = 4;
  localparam int NUM_CAL        = 3;
  localparam int CH_W           = 2;
  localparam int PULSE_BITS_DEF = 16;
  localparam int CAL_W          = 16;
  localparam int SPREAD_W       = 8;
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 16;
  localparam int LEVEL_W        = 25;
  localparam int RAW_MIN_W      = 15;
  localparam int RAW_MAX_W      = 17;
  localparam int CLASS_W        = 3;

  // level = 255 - (w - low) * 255 / (high - low); 255 = 2^SCALE_SH - 1
  localparam int SCALE_SH   = 8;
  localparam int FULL_SCALE = 255;
  localparam int MEAN_DIV   = 3;
  localparam int MIN_RST    = 32767;
  localparam int MAX_RST    = -32768;

  localparam logic [CH_W-1:0] CH_RED   = 2'd0;
  localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
  localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;
  localparam logic [CH_W-1:0] CH_CLEAR = 2'd3;

  localparam logic [CAL_W-1:0]    RED_LO_RST   = 16'd1;
  localparam logic [CAL_W-1:0]    RED_HI_RST   = 16'd111;
  localparam logic [CAL_W-1:0]    GREEN_LO_RST = 16'd2;
  localparam logic [CAL_W-1:0]    GREEN_HI_RST = 16'd125;
  localparam logic [CAL_W-1:0]    BLUE_LO_RST  = 16'd1;
  localparam logic [CAL_W-1:0]    BLUE_HI_RST  = 16'd101;
  localparam logic [SPREAD_W-1:0] SPREAD_RST   = 8'd8;
  localparam logic [CAL_W-1:0]    WHITE_RST    = 16'd660;
  localparam logic [CAL_W-1:0]    CLEAR_LO     = 16'd0;
  localparam logic [CAL_W-1:0]    CLEAR_HI     = 16'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED_LO   = 4'd0,
    REG_RED_HI   = 4'd1,
    REG_GREEN_LO = 4'd2,
    REG_GREEN_HI = 4'd3,
    REG_BLUE_LO  = 4'd4,
    REG_BLUE_HI  = 4'd5,
    REG_GRAY     = 4'd6,
    REG_WHITE    = 4'd7
  } reg_idx_t;

  typedef enum logic [CLASS_W-1:0] {
    CLS_RED       = 3'd0,
    CLS_GREEN     = 3'd1,
    CLS_BLUE      = 3'd2,
    CLS_BLACK     = 3'd3,
    CLS_WHITE     = 3'd4,
    CLS_UNDEF     = 3'd5,
    CLS_UNDECIDED = 3'd6
  } color_class_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_LOAD,
    ST_DIV_MAP,
    ST_LEVEL,
    ST_SUM,
    ST_GRAY,
    ST_DIV_MEAN,
    ST_MEAN,
    ST_DIST,
    ST_DECIDE
  } state_t;

endpackage

// ===== rtl/rgb_pcc_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: sample input, result output, register write.
interface rgb_pcc_in_if import rgb_pcc_pkg::*; #(
  parameter int PULSE_BITS = PULSE_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [CH_W-1:0]       channel;
  logic [PULSE_BITS-1:0] pulse_width;

  modport source (output valid, channel, pulse_width, input ready);
  modport sink   (input valid, channel, pulse_width, output ready);
endinterface

interface rgb_pcc_out_if import rgb_pcc_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [LEVEL_W-1:0]   mapped_level;
  logic        [RAW_MIN_W-1:0] raw_minimum;
  logic signed [RAW_MAX_W-1:0] raw_maximum;
  logic        [CLASS_W-1:0]   color_class;

  modport source (output valid, mapped_level, raw_minimum, raw_maximum, color_class,
                  input ready);
  modport sink   (input valid, mapped_level, raw_minimum, raw_maximum, color_class,
                  output ready);
endinterface

interface rgb_pcc_cfg_if import rgb_pcc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/rgb_pulse_color_classifier_unit.sv =====
`timescale 1ns / 1ps
// RGB pulse color classifier: per-channel min/max, inverse level mapping, color class.
//
// in_ch carries one beat per sensor reading (channel, raw low-pulse width).
// out_ch returns one beat per reading: mapped level, channel min/max, color class.
// cfg_ch writes calibration and threshold registers and is always ready; the user
// must write it only while the block is idle, which the block does not enforce.
// One reading is processed at a time: in_ch.ready is high only when idle.
// Writes to unknown indexes are dropped. A reading passes through PREP, LOAD,
// the level division, LEVEL, SUM and GRAY; a non-gray reading then runs the mean
// division, MEAN and DIST before DECIDE. The divider is radix-2 restoring, one
// quotient bit per cycle, shared by the level division and the mean divide-by-3.
// Results sit in an output register; the block takes the next reading while a
// result waits, and holds a finished result until the output register is free.
// Synchronous active-low reset restores register defaults, clears stored
// levels, sets minima to 32767 and maxima to -32768, and drops any result.
module rgb_pulse_color_classifier_unit import rgb_pcc_pkg::*; #(
  parameter int PULSE_BITS = PULSE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  rgb_pcc_in_if.sink   in_ch,
  rgb_pcc_out_if.source out_ch,
  rgb_pcc_cfg_if.sink  cfg_ch
);

  localparam int W_EXT  = (PULSE_BITS > CAL_W) ? PULSE_BITS : CAL_W;
  localparam int D_W    = W_EXT + 1;
  localparam int MAG_W  = W_EXT + SCALE_SH;
  localparam int LVL_W  = MAG_W + 2;
  localparam int SUM_W  = LVL_W + 2;
  localparam int DIV_W  = MAG_W + 3;
  localparam int DEN_W  = CAL_W;
  localparam int CNT_W  = $clog2(DIV_W);
  localparam int DIST_W = SUM_W + 1;
  localparam int MAX_W  = W_EXT + 1;
  localparam logic signed [LVL_W-1:0] LVL_FULL = LVL_W'(FULL_SCALE);

  state_t state_r, state_nxt;

  logic [CAL_W-1:0]    cal_lo_r [NUM_CAL];
  logic [CAL_W-1:0]    cal_hi_r [NUM_CAL];
  logic [SPREAD_W-1:0] spread_r;
  logic [CAL_W-1:0]    thr_white_r;

  logic signed [LVL_W-1:0] lvl_r [NUM_CHANNELS];
  logic [RAW_MIN_W-1:0]    min_r [NUM_CHANNELS];
  logic signed [MAX_W-1:0] max_r [NUM_CHANNELS];

  logic [CH_W-1:0]       ch_r;
  logic [PULSE_BITS-1:0] w_r;
  logic signed [D_W-1:0] d_r;
  logic signed [CAL_W:0] run_r;
  logic                  neg_r;
  logic                  zero_run_r;

  logic [DIV_W-1:0] div_num_r;
  logic [DEN_W-1:0] div_rem_r;
  logic [DEN_W-1:0] div_den_r;
  logic [CNT_W-1:0] div_cnt_r;

  logic signed [SUM_W-1:0] sum_r;
  logic signed [LVL_W:0]   dif_rg_r, dif_rb_r, dif_gb_r;
  logic                    gray_r, bright_r;
  logic signed [SUM_W-1:0] mean_r;
  logic [DIST_W-1:0]       dist_red_r, dist_green_r, dist_blue_r;

  logic                        out_valid_r;
  logic signed [LEVEL_W-1:0]   out_level_r;
  logic        [RAW_MIN_W-1:0] out_min_r;
  logic signed [RAW_MAX_W-1:0] out_max_r;
  color_class_t                out_class_r;

  logic         in_ready;
  logic         in_take;
  logic         out_load;
  logic         div_step;
  logic         div_last;
  logic         gray_c;
  color_class_t cls_c;

  logic [CH_W-1:0]  ch_in;
  logic [W_EXT-1:0] w_ext;
  logic             w_lt_min, w_gt_max;

  logic [CAL_W-1:0]        sel_lo, sel_hi;
  logic signed [D_W-1:0]   d_c;
  logic signed [CAL_W:0]   run_c;
  logic signed [D_W-1:0]   d_abs_full;
  logic [W_EXT-1:0]        d_abs;
  logic [MAG_W-1:0]        mag_c;
  logic signed [CAL_W:0]   run_abs_full;
  logic [DEN_W:0]          div_shift;
  logic [DEN_W+1:0]        div_trial;
  logic                    div_take;
  logic signed [LVL_W-1:0] quo_lvl, lvl_new;
  logic signed [LVL_W-1:0] lv_red, lv_green, lv_blue;
  logic [LVL_W:0]          adif_rg, adif_rb, adif_gb;
  logic [LVL_W:0]          spread_ext;
  logic signed [SUM_W-1:0] sum_abs_full;
  logic signed [SUM_W-1:0] quo_mean;
  logic signed [DIST_W-1:0] dm_red, dm_green, dm_blue;

  assign lv_red   = lvl_r[CH_RED];
  assign lv_green = lvl_r[CH_GREEN];
  assign lv_blue  = lvl_r[CH_BLUE];

  // input side: min/max compare at acceptance
  assign ch_in    = in_ch.channel;
  assign w_ext    = W_EXT'(in_ch.pulse_width);
  assign w_lt_min = w_ext < W_EXT'(min_r[ch_in]);
  assign w_gt_max = signed'(MAX_W'(w_ext)) > max_r[ch_in];

  always_comb begin
    unique case (ch_r)
      CH_RED: begin
        sel_lo = cal_lo_r[CH_RED];
        sel_hi = cal_hi_r[CH_RED];
      end
      CH_GREEN: begin
        sel_lo = cal_lo_r[CH_GREEN];
        sel_hi = cal_hi_r[CH_GREEN];
      end
      CH_BLUE: begin
        sel_lo = cal_lo_r[CH_BLUE];
        sel_hi = cal_hi_r[CH_BLUE];
      end
      CH_CLEAR: begin
        sel_lo = CLEAR_LO;
        sel_hi = CLEAR_HI;
      end
    endcase
  end

  // level mapping operands
  always_comb begin
    d_c          = signed'(D_W'(w_r)) - signed'(D_W'(sel_lo));
    run_c        = signed'({1'b0, sel_hi}) - signed'({1'b0, sel_lo});
    d_abs_full   = d_r[D_W-1] ? -d_r : d_r;
    d_abs        = d_abs_full[W_EXT-1:0];
    mag_c        = {d_abs, {SCALE_SH{1'b0}}} - MAG_W'(d_abs);
    run_abs_full = run_r[CAL_W] ? -run_r : run_r;
  end

  // restoring divider, one quotient bit per cycle
  always_comb begin
    div_shift = {div_rem_r, div_num_r[DIV_W-1]};
    div_trial = {1'b0, div_shift} - {2'b00, div_den_r};
    div_take  = !div_trial[DEN_W+1];
  end

  always_comb begin
    quo_lvl  = signed'(LVL_W'(div_num_r[MAG_W-1:0]));
    lvl_new  = zero_run_r ? LVL_FULL : ((neg_r ? -quo_lvl : quo_lvl) + LVL_FULL);
    quo_mean = signed'(SUM_W'(div_num_r));
  end

  always_comb begin
    adif_rg      = dif_rg_r[LVL_W] ? unsigned'(-dif_rg_r) : unsigned'(dif_rg_r);
    adif_rb      = dif_rb_r[LVL_W] ? unsigned'(-dif_rb_r) : unsigned'(dif_rb_r);
    adif_gb      = dif_gb_r[LVL_W] ? unsigned'(-dif_gb_r) : unsigned'(dif_gb_r);
    spread_ext   = (LVL_W+1)'(spread_r);
    gray_c       = (adif_rg < spread_ext) && (adif_rb < spread_ext) && (adif_gb < spread_ext);
    sum_abs_full = sum_r[SUM_W-1] ? -sum_r : sum_r;
    dm_red       = DIST_W'(mean_r) - DIST_W'(lv_red);
    dm_green     = DIST_W'(mean_r) - DIST_W'(lv_green);
    dm_blue      = DIST_W'(mean_r) - DIST_W'(lv_blue);
  end

  always_comb begin
    priority if (gray_r) begin
      cls_c = bright_r ? CLS_WHITE : CLS_BLACK;
    end else if (dist_red_r > dist_green_r && dist_red_r > dist_blue_r) begin
      cls_c = (lv_red < lv_green || lv_red < lv_blue) ? CLS_UNDEF : CLS_RED;
    end else if (dist_green_r > dist_red_r && dist_green_r > dist_blue_r) begin
      cls_c = (lv_green < lv_red || lv_green < lv_blue) ? CLS_UNDEF : CLS_GREEN;
    end else if (dist_blue_r > dist_red_r && dist_blue_r > dist_green_r) begin
      cls_c = (lv_blue < lv_red || lv_blue < lv_green) ? CLS_UNDEF : CLS_BLUE;
    end else begin
      cls_c = CLS_UNDECIDED;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_ch.valid) state_nxt = ST_PREP;
      ST_PREP:     state_nxt = ST_LOAD;
      ST_LOAD:     state_nxt = ST_DIV_MAP;
      ST_DIV_MAP:  if (div_last) state_nxt = ST_LEVEL;
      ST_LEVEL:    state_nxt = ST_SUM;
      ST_SUM:      state_nxt = ST_GRAY;
      ST_GRAY:     state_nxt = gray_c ? ST_DECIDE : ST_DIV_MEAN;
      ST_DIV_MEAN: if (div_last) state_nxt = ST_MEAN;
      ST_MEAN:     state_nxt = ST_DIST;
      ST_DIST:     state_nxt = ST_DECIDE;
      ST_DECIDE:   if (out_load) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = (state_r == ST_IDLE);
    in_take  = in_ready && in_ch.valid;
    out_load = (state_r == ST_DECIDE) && (!out_valid_r || out_ch.ready);
    div_step = (state_r == ST_DIV_MAP) || (state_r == ST_DIV_MEAN);
    div_last = (div_cnt_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r              <= ST_IDLE;
      out_valid_r          <= 1'b0;
      cal_lo_r[CH_RED]     <= RED_LO_RST;
      cal_hi_r[CH_RED]     <= RED_HI_RST;
      cal_lo_r[CH_GREEN]   <= GREEN_LO_RST;
      cal_hi_r[CH_GREEN]   <= GREEN_HI_RST;
      cal_lo_r[CH_BLUE]    <= BLUE_LO_RST;
      cal_hi_r[CH_BLUE]    <= BLUE_HI_RST;
      spread_r             <= SPREAD_RST;
      thr_white_r          <= WHITE_RST;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        lvl_r[i] <= '0;
        min_r[i] <= RAW_MIN_W'(MIN_RST);
        max_r[i] <= MAX_W'(MAX_RST);
      end
    end else begin
      state_r <= state_nxt;

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          REG_RED_LO:   cal_lo_r[CH_RED]   <= cfg_ch.data;
          REG_RED_HI:   cal_hi_r[CH_RED]   <= cfg_ch.data;
          REG_GREEN_LO: cal_lo_r[CH_GREEN] <= cfg_ch.data;
          REG_GREEN_HI: cal_hi_r[CH_GREEN] <= cfg_ch.data;
          REG_BLUE_LO:  cal_lo_r[CH_BLUE]  <= cfg_ch.data;
          REG_BLUE_HI:  cal_hi_r[CH_BLUE]  <= cfg_ch.data;
          REG_GRAY:     spread_r           <= cfg_ch.data[SPREAD_W-1:0];
          REG_WHITE:    thr_white_r        <= cfg_ch.data;
          default: ;
        endcase
      end

      if (in_take) begin
        if (w_lt_min) begin
          min_r[ch_in] <= w_ext[RAW_MIN_W-1:0];
        end else if (w_gt_max) begin
          max_r[ch_in] <= signed'(MAX_W'(w_ext));
        end
      end

      if (state_r == ST_LEVEL) begin
        lvl_r[ch_r] <= lvl_new;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_take) begin
      ch_r <= ch_in;
      w_r  <= in_ch.pulse_width;
    end

    unique case (state_r)
      ST_PREP: begin
        d_r   <= d_c;
        run_r <= run_c;
      end
      ST_LOAD: begin
        div_num_r  <= DIV_W'(mag_c);
        div_den_r  <= run_abs_full[DEN_W-1:0];
        div_rem_r  <= '0;
        div_cnt_r  <= CNT_W'(DIV_W - 1);
        neg_r      <= (!d_r[D_W-1] && (d_r != '0)) ^ run_r[CAL_W];
        zero_run_r <= (run_r == '0);
      end
      ST_DIV_MAP, ST_DIV_MEAN: begin
        div_num_r <= {div_num_r[DIV_W-2:0], div_take};
        div_rem_r <= div_take ? div_trial[DEN_W-1:0] : div_shift[DEN_W-1:0];
        div_cnt_r <= div_cnt_r - 1'b1;
      end
      ST_SUM: begin
        sum_r    <= SUM_W'(lv_red) + SUM_W'(lv_green) + SUM_W'(lv_blue);
        dif_rg_r <= (LVL_W+1)'(lv_red) - (LVL_W+1)'(lv_green);
        dif_rb_r <= (LVL_W+1)'(lv_red) - (LVL_W+1)'(lv_blue);
        dif_gb_r <= (LVL_W+1)'(lv_green) - (LVL_W+1)'(lv_blue);
      end
      ST_GRAY: begin
        gray_r    <= gray_c;
        bright_r  <= sum_r > signed'(SUM_W'(thr_white_r));
        div_num_r <= sum_abs_full[DIV_W-1:0];
        div_den_r <= DEN_W'(MEAN_DIV);
        div_rem_r <= '0;
        div_cnt_r <= CNT_W'(DIV_W - 1);
        neg_r     <= sum_r[SUM_W-1];
      end
      ST_MEAN: begin
        mean_r <= neg_r ? -quo_mean : quo_mean;
      end
      ST_DIST: begin
        dist_red_r   <= dm_red[DIST_W-1]   ? unsigned'(-dm_red)   : unsigned'(dm_red);
        dist_green_r <= dm_green[DIST_W-1] ? unsigned'(-dm_green) : unsigned'(dm_green);
        dist_blue_r  <= dm_blue[DIST_W-1]  ? unsigned'(-dm_blue)  : unsigned'(dm_blue);
      end
      default: ;
    endcase

    if (out_load) begin
      out_level_r <= lvl_r[ch_r][LEVEL_W-1:0];
      out_min_r   <= min_r[ch_r];
      out_max_r   <= max_r[ch_r][RAW_MAX_W-1:0];
      out_class_r <= cls_c;
    end
  end

  assign in_ch.ready         = in_ready;
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.mapped_level = out_level_r;
  assign out_ch.raw_minimum  = out_min_r;
  assign out_ch.raw_maximum  = out_max_r;
  assign out_ch.color_class  = out_class_r;

endmodule

// ===== rtl/rgb_pcc_checker.sv =====
`timescale 1ns / 1ps
// Port-level assertions for the classifier, bound to the top level.
module rgb_pcc_checker import rgb_pcc_pkg::*; (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic signed [LEVEL_W-1:0]   out_level,
  input logic        [RAW_MIN_W-1:0] out_min,
  input logic signed [RAW_MAX_W-1:0] out_max,
  input logic        [CLASS_W-1:0]   out_class
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_level) && $stable(out_min) &&
                                $stable(out_max) && $stable(out_class))
    else $error("result payload changed while stalled");

  a_class_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_class <= CLS_UNDECIDED)
    else $error("color class out of range");

  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared one cycle after input beat");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind rgb_pulse_color_classifier_unit rgb_pcc_checker u_rgb_pcc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_level (out_ch.mapped_level),
  .out_min   (out_ch.raw_minimum),
  .out_max   (out_ch.raw_maximum),
  .out_class (out_ch.color_class)
);

// ===== bench/rgb_pulse_color_classifier_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the RGB pulse color classifier unit.
module rgb_pulse_color_classifier_unit_tb;
  import rgb_pcc_pkg::*;

  localparam int     REG_COUNT    = int'(REG_WHITE) + 1;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'd12;
  localparam longint MAX_WIDTH    = (longint'(1) << PULSE_BITS_DEF) - 1;
  localparam int     FRAC_ONE     = 256;
  localparam int     NUM_PHASES   = 8;
  localparam int     PHASE_ITEMS  = 230;
  localparam int     IDLE_PCT     = 58;
  localparam int     BOTH_PCT     = 27;
  localparam int     END_HOLD     = 80;
  localparam int     IDLE_LIMIT   = 5000;
  localparam int     PRINT_LIMIT  = 40;

  typedef struct packed {
    logic signed [LEVEL_W-1:0]   level;
    logic        [RAW_MIN_W-1:0] raw_min;
    logic signed [RAW_MAX_W-1:0] raw_max;
    color_class_t                cls;
  } reading_t;

  typedef enum logic {ROW_READ, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  sel;
    logic [CFG_DATA_W-1:0] value;
    logic                  checked;
    reading_t              want;
  } plan_row_t;

  localparam int PLAN_LEN = 29;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{ROW_READ, CH_RED,       16'd1,     1'b1, '{25'sd255,    15'd1, -17'sd32768, CLS_RED}},
    '{ROW_READ, CH_GREEN,     16'd2,     1'b1, '{25'sd255,    15'd2, -17'sd32768, CLS_UNDEF}},
    '{ROW_READ, CH_BLUE,      16'd1,     1'b1, '{25'sd255,    15'd1, -17'sd32768, CLS_WHITE}},
    '{ROW_READ, CH_CLEAR,     16'd0,     1'b1, '{25'sd255,    15'd0, -17'sd32768, CLS_WHITE}},
    '{ROW_READ, CH_CLEAR,     16'd65535, 1'b1, '{-25'sd65280, 15'd0, 17'sd65535,  CLS_WHITE}},
    '{ROW_READ, CH_RED,       16'd65535, 1'b0, '0},
    '{ROW_READ, CH_GREEN,     16'd0,     1'b0, '0},
    '{ROW_READ, CH_BLUE,      16'd51,    1'b0, '0},
    '{ROW_REG,  REG_GRAY,     16'd0,     1'b0, '0},
    '{ROW_READ, CH_RED,       16'd1,     1'b0, '0},
    '{ROW_READ, CH_GREEN,     16'd2,     1'b0, '0},
    '{ROW_READ, CH_BLUE,      16'd1,     1'b0, '0},
    '{ROW_REG,  REG_RED_LO,   16'd300,   1'b0, '0},
    '{ROW_REG,  REG_RED_HI,   16'd300,   1'b0, '0},
    '{ROW_READ, CH_RED,       16'd7,     1'b0, '0},
    '{ROW_REG,  REG_GRAY,     16'hFFFF,  1'b0, '0},
    '{ROW_REG,  REG_UNMAPPED, 16'd0,     1'b0, '0},
    '{ROW_REG,  REG_WHITE,    16'd0,     1'b0, '0},
    '{ROW_READ, CH_GREEN,     16'd60,    1'b0, '0},
    '{ROW_REG,  REG_WHITE,    16'hFFFF,  1'b0, '0},
    '{ROW_READ, CH_BLUE,      16'd60,    1'b0, '0},
    '{ROW_REG,  REG_GREEN_LO, 16'hFFFF,  1'b0, '0},
    '{ROW_REG,  REG_GREEN_HI, 16'd0,     1'b0, '0},
    '{ROW_READ, CH_GREEN,     16'd65535, 1'b0, '0},
    '{ROW_READ, CH_GREEN,     16'd0,     1'b0, '0},
    '{ROW_REG,  REG_BLUE_LO,  16'd0,     1'b0, '0},
    '{ROW_REG,  REG_BLUE_HI,  16'hFFFF,  1'b0, '0},
    '{ROW_READ, CH_BLUE,      16'd65535, 1'b0, '0},
    '{ROW_READ, CH_CLEAR,     16'd128,   1'b0, '0}
  };

  logic clk;
  logic rst_n;

  rgb_pcc_in_if #(.PULSE_BITS(PULSE_BITS_DEF)) in_ch ();
  rgb_pcc_out_if out_ch ();
  rgb_pcc_cfg_if cfg_ch ();

  rgb_pulse_color_classifier_unit #(.PULSE_BITS(PULSE_BITS_DEF)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor state
  logic [CAL_W-1:0]    cal_lo [NUM_CAL];
  logic [CAL_W-1:0]    cal_hi [NUM_CAL];
  logic [SPREAD_W-1:0] gray_spread;
  logic [CAL_W-1:0]    white_sum;
  longint              lvl_now  [NUM_CHANNELS];
  longint              pw_floor [NUM_CHANNELS];
  longint              pw_peak  [NUM_CHANNELS];

  reading_t results_due [$];
  reading_t typed_want;
  reading_t predicted;
  reading_t due;
  bit       typed_pending;
  int       mismatch_count;
  int       idle_cycles;
  int       src_idle_pct;
  int       sink_stall_pct;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic reading_t predict_reading(logic [CH_W-1:0] ch,
                                               logic [PULSE_BITS_DEF-1:0] pw);
    longint   w, lo, hi, run, r, g, b, sp, wt, mean, dr, dg, db;
    reading_t res;
    w = pw;
    if (w < pw_floor[ch]) pw_floor[ch] = w;
    else if (w > pw_peak[ch]) pw_peak[ch] = w;
    if (ch == CH_CLEAR) begin
      lo = CLEAR_LO;
      hi = CLEAR_HI;
    end else begin
      lo = cal_lo[ch];
      hi = cal_hi[ch];
    end
    run = hi - lo;
    lvl_now[ch] = (run == 0) ? longint'(FULL_SCALE)
                             : (w - lo) * (-FULL_SCALE) / run + FULL_SCALE;
    r  = lvl_now[CH_RED];
    g  = lvl_now[CH_GREEN];
    b  = lvl_now[CH_BLUE];
    sp = gray_spread;
    wt = white_sum;
    if (mag(r - g) < sp && mag(r - b) < sp && mag(g - b) < sp) begin
      res.cls = (r + g + b > wt) ? CLS_WHITE : CLS_BLACK;
    end else begin
      mean = (r + g + b) / MEAN_DIV;
      dr = mag(mean - r);
      dg = mag(mean - g);
      db = mag(mean - b);
      if (dr > dg && dr > db) res.cls = (r < g || r < b) ? CLS_UNDEF : CLS_RED;
      else if (dg > dr && dg > db) res.cls = (g < r || g < b) ? CLS_UNDEF : CLS_GREEN;
      else if (db > dr && db > dg) res.cls = (b < r || b < g) ? CLS_UNDEF : CLS_BLUE;
      else res.cls = CLS_UNDECIDED;
    end
    res.level   = lvl_now[ch][LEVEL_W-1:0];
    res.raw_min = pw_floor[ch][RAW_MIN_W-1:0];
    res.raw_max = pw_peak[ch][RAW_MAX_W-1:0];
    return res;
  endfunction

  function automatic logic [PULSE_BITS_DEF-1:0] pick_width(int ch, int frac, int jit);
    longint lo, hi, w;
    if (ch == CH_CLEAR) begin
      lo = CLEAR_LO;
      hi = CLEAR_HI;
    end else begin
      lo = cal_lo[ch];
      hi = cal_hi[ch];
    end
    w = lo + (hi - lo) * frac / FRAC_ONE + jit;
    if (w < 0) w = 0;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w[PULSE_BITS_DEF-1:0];
  endfunction

  function automatic void rand_cal(output logic [CAL_W-1:0] lo, output logic [CAL_W-1:0] hi);
    case ($urandom_range(0, 9))
      0: begin
        lo = $urandom_range(0, 65535);
        hi = lo;
      end
      1: begin
        lo = '0;
        hi = '1;
      end
      2: begin
        lo = '1;
        hi = '0;
      end
      3: begin
        lo = $urandom_range(0, 65535);
        hi = $urandom_range(0, 65535);
      end
      default: begin
        lo = $urandom_range(0, 200);
        hi = lo + $urandom_range(1, 400);
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
  endtask

  task automatic push_reading(input logic [CH_W-1:0] ch,
                              input logic [PULSE_BITS_DEF-1:0] pw);
    cfg_ch.valid <= 1'b0;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.channel     <= ch;
    in_ch.pulse_width <= pw;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_RED_LO, REG_GREEN_LO, REG_BLUE_LO: cal_lo[cfg_ch.index >> 1] = cfg_ch.data;
        REG_RED_HI, REG_GREEN_HI, REG_BLUE_HI: cal_hi[cfg_ch.index >> 1] = cfg_ch.data;
        REG_GRAY:  gray_spread = cfg_ch.data[SPREAD_W-1:0];
        REG_WHITE: white_sum = cfg_ch.data;
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predicted = predict_reading(in_ch.channel, in_ch.pulse_width);
      if (typed_pending) begin
        results_due.push_back(typed_want);
        typed_pending = 1'b0;
      end else begin
        results_due.push_back(predicted);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (results_due.size() == 0) begin
        report_mismatch("unexpected result beat", 0, 0);
      end else begin
        due = results_due.pop_front();
        if (out_ch.mapped_level !== due.level)
          report_mismatch("mapped_level", out_ch.mapped_level, $signed(due.level));
        if (out_ch.raw_minimum !== due.raw_min)
          report_mismatch("raw_minimum", out_ch.raw_minimum, due.raw_min);
        if (out_ch.raw_maximum !== due.raw_max)
          report_mismatch("raw_maximum", out_ch.raw_maximum, $signed(due.raw_max));
        if (out_ch.color_class !== due.cls)
          report_mismatch("color_class", out_ch.color_class, due.cls);
      end
    end
  end

  always @(negedge clk) out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int                    k, jmax, pick, sent, c;
    logic [PULSE_BITS_DEF-1:0] w;
    logic [CFG_DATA_W-1:0] reg_val [REG_COUNT];

    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.channel     = '0;
    in_ch.pulse_width = '0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.data       = '0;
    mismatch_count    = 0;
    idle_cycles       = 0;
    typed_pending     = 1'b0;
    src_idle_pct      = 0;
    sink_stall_pct    = 0;
    cal_lo      = '{RED_LO_RST, GREEN_LO_RST, BLUE_LO_RST};
    cal_hi      = '{RED_HI_RST, GREEN_HI_RST, BLUE_HI_RST};
    gray_spread = SPREAD_RST;
    white_sum   = WHITE_RST;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      lvl_now[i]  = 0;
      pw_floor[i] = MIN_RST;
      pw_peak[i]  = MAX_RST;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].kind == ROW_REG) begin
        wait_drain();
        write_reg(PLAN[i].sel, PLAN[i].value);
      end else begin
        typed_want    = PLAN[i].want;
        typed_pending = PLAN[i].checked;
        push_reading(PLAN[i].sel[CH_W-1:0], PLAN[i].value);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drain();
      case (ph % 4)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = IDLE_PCT;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = IDLE_PCT;
        end
        default: begin
          src_idle_pct   = BOTH_PCT;
          sink_stall_pct = BOTH_PCT;
        end
      endcase

      if (ph == 0) begin
        reg_val = '{RED_LO_RST, RED_HI_RST, GREEN_LO_RST, GREEN_HI_RST,
                    BLUE_LO_RST, BLUE_HI_RST, CFG_DATA_W'(SPREAD_RST), WHITE_RST};
      end else begin
        for (int i = 0; i < NUM_CAL; i++) rand_cal(reg_val[2*i], reg_val[2*i+1]);
        case ($urandom_range(0, 4))
          0: reg_val[REG_GRAY] = '0;
          1: reg_val[REG_GRAY] = '1;
          2: reg_val[REG_GRAY] = $urandom_range(0, 65535);
          default: reg_val[REG_GRAY] = $urandom_range(1, 40);
        endcase
        case ($urandom_range(0, 3))
          0: reg_val[REG_WHITE] = '0;
          1: reg_val[REG_WHITE] = '1;
          default: reg_val[REG_WHITE] = $urandom_range(300, 800);
        endcase
      end
      for (int i = 0; i < REG_COUNT; i++) write_reg(CFG_IDX_W'(i), reg_val[i]);
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, 2**CFG_IDX_W - 1)),
                  CFG_DATA_W'($urandom));

      // mostly RGB triples at a shared calibration fraction so gray and outlier
      // cases are hit; the rest are single readings and raw noise
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          case ($urandom_range(0, 2))
            0: jmax = 2;
            1: jmax = 20;
            default: jmax = 200;
          endcase
          k = $urandom_range(0, FRAC_ONE);
          for (int i = 0; i < NUM_CAL; i++)
            push_reading(CH_W'(i), pick_width(i, k, int'($urandom_range(0, 2*jmax)) - jmax));
          sent += NUM_CAL;
        end else if (pick < 85) begin
          c = $urandom_range(0, NUM_CHANNELS - 1);
          push_reading(CH_W'(c), pick_width(c, int'($urandom_range(0, FRAC_ONE + 64)) - 32, 0));
          sent++;
        end else begin
          case ($urandom_range(0, 3))
            0: w = '0;
            1: w = '1;
            default: w = $urandom_range(0, MAX_WIDTH);
          endcase
          push_reading(CH_W'($urandom_range(0, NUM_CHANNELS - 1)), w);
          sent++;
        end
      end
    end

    wait_drain();
    repeat (END_HOLD) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rgb_pcc_pkg.sv
rtl/rgb_pcc_if.sv
rtl/rgb_pulse_color_classifier_unit.sv
rtl/rgb_pcc_checker.sv
bench/rgb_pulse_color_classifier_unit_tb.sv
